// ===== src/idc_pkg.sv =====
package idc_pkg;

   localparam int FlagWidth   = 5;
   localparam int VectorWidth = 7;
   localparam int ActionWidth = 3;
   localparam int JoypadBit   = 4;

   typedef logic [FlagWidth-1:0]   flags_type;
   typedef logic [VectorWidth-1:0] vector_type;

   // Action codes carried in the low bits of the request beat.
   typedef enum logic [ActionWidth-1:0] {
      ACT_CHECK = 3'd0,
      ACT_EI    = 3'd1,
      ACT_DI    = 3'd2,
      ACT_HALT  = 3'd3,
      ACT_STOP  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ME_DISABLED  = 2'd0,
      ME_SCHEDULED = 2'd1,
      ME_NEXT      = 2'd2,
      ME_ENABLED   = 2'd3
   } me_state_type;

   typedef enum logic [1:0] {
      RUN_RUNNING = 2'd0,
      RUN_HALTED  = 2'd1,
      RUN_STOPPED = 2'd2
   } run_state_type;

   typedef struct packed {
      me_state_type  me;
      run_state_type run;
   } ctl_state_type;

   typedef struct packed {
      logic [ActionWidth-1:0] action;
      flags_type              pending;
      flags_type              enables;
   } item_type;

   typedef struct packed {
      run_state_type run;
      me_state_type  me;
      logic          take;
      vector_type    vector;
      flags_type     pending_after;
   } result_type;

   localparam vector_type VectorTable [FlagWidth] = '{
      7'h40, 7'h48, 7'h50, 7'h58, 7'h60
   };

endpackage

// ===== src/idc_dispatch.sv =====
module idc_dispatch
   import idc_pkg::*;
(
   input  ctl_state_type state_cur,
   input  item_type      item,
   output ctl_state_type state_nxt,
   output result_type    result
);

   me_state_type me_adv;
   flags_type    masked;
   logic         wake;
   logic         take;
   logic [2:0]   first_idx;

   // The delayed re-enable moves one step on every check, before masking.
   always_comb begin
      me_adv = state_cur.me;
      case (state_cur.me)
         ME_SCHEDULED: me_adv = ME_NEXT;
         ME_NEXT:      me_adv = ME_ENABLED;
         default:      me_adv = state_cur.me;
      endcase
   end

   assign masked = item.pending & item.enables;
   assign wake   = ((masked != '0) && (state_cur.run == RUN_HALTED)) ||
                   (masked[JoypadBit] && (state_cur.run == RUN_STOPPED));
   assign take   = (item.action == ACT_CHECK) && !wake &&
                   (me_adv == ME_ENABLED) && (masked != '0);

   // Lowest set bit has the highest priority.
   always_comb begin
      first_idx = '0;
      for (int i = FlagWidth - 1; i >= 0; i--) begin
         if (masked[i]) begin
            first_idx = 3'(i);
         end
      end
   end

   // Next state.
   always_comb begin
      state_nxt = state_cur;
      case (item.action)
         ACT_CHECK: begin
            state_nxt.me = take ? ME_DISABLED : me_adv;
            if (wake) begin
               state_nxt.run = RUN_RUNNING;
            end
         end
         ACT_EI:   state_nxt.me  = ME_SCHEDULED;
         ACT_DI:   state_nxt.me  = ME_DISABLED;
         ACT_HALT: state_nxt.run = RUN_HALTED;
         ACT_STOP: state_nxt.run = RUN_STOPPED;
         default:  state_nxt = state_cur;
      endcase
   end

   // Result beat.
   always_comb begin
      result.run           = state_nxt.run;
      result.me            = state_nxt.me;
      result.take          = take;
      result.vector        = '0;
      result.pending_after = item.pending;
      if (take) begin
         result.vector        = VectorTable[first_idx];
         result.pending_after = item.pending & ~(flags_type'(1) << first_idx);
      end
   end

endmodule

// ===== src/interrupt_dispatch_controller.sv =====
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: action, pending_flags, enable_flags
// rsp      out  rsp_tvalid/rsp_tready  tdata: pending_after, vector_address,
//                                      run_state, enable_state; tuser: take_interrupt
//
// One beat in, one beat out; a new beat is taken every cycle unless a stalled result fills both stages.
// A beat passes through two registers: the input register, then the result register.
// State updates when a beat moves from the input register to the result register.
// Reset clears both valid flags, the master enable (disabled) and the run state.
// A stalled result holds both stages; req_tready drops only when both are full.
module interrupt_dispatch_controller
   import idc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] action, [7:3] pending_flags, [12:8] enable_flags
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] pending_after, [11:5] vector_address,
                                    // [13:12] run_state, [15:14] enable_state
   output logic        rsp_tuser    // [0] take_interrupt
);

   logic          in_valid_ff, in_valid_in;
   item_type      in_item_ff;
   logic          out_valid_ff, out_valid_in;
   result_type    out_data_ff;
   ctl_state_type state_ff, state_in;
   ctl_state_type state_calc;
   result_type    result_calc;
   logic          out_free;
   logic          advance;
   logic          req_accept;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   idc_dispatch u_dispatch (
      .state_cur (state_ff),
      .item      (in_item_ff),
      .state_nxt (state_calc),
      .result    (result_calc)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      state_in = advance ? state_calc : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{me: ME_DISABLED, run: RUN_RUNNING};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.action  <= req_tdata[2:0];
         in_item_ff.pending <= req_tdata[7:3];
         in_item_ff.enables <= req_tdata[12:8];
      end
      if (advance) begin
         out_data_ff <= result_calc;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff.me, out_data_ff.run, out_data_ff.vector,
                        out_data_ff.pending_after};
   assign rsp_tuser  = out_data_ff.take;

endmodule

// ===== src/idc_checker.sv =====
module idc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A result beat is never offered in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Dispatch always drops the master enable and gives a vector.
   a_take_clears_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:14] == 2'd0 && rsp_tdata[11:5] != 7'd0)
      else $error("dispatch beat with master enable still on or no vector");

   a_no_take_no_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[11:5] == 7'd0)
      else $error("vector reported without a dispatch");

   // A halted CPU wakes on any enabled request instead of dispatching it.
   a_take_not_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[13:12] != 2'd1)
      else $error("dispatch reported while halted");

endmodule

bind interrupt_dispatch_controller idc_checker u_idc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
